// ----- src/vmt_pkg.sv -----
// Shared types and constants for the 4x4 vector-matrix transform.
package vmt_pkg;

  localparam int ELEM_W    = 32;
  localparam int NUM_ROWS  = 4;
  localparam int NUM_COLS  = 4;
  localparam int ROW_W     = $clog2(NUM_ROWS);
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = PROD_W + $clog2(NUM_COLS);
  localparam int FRAC_BITS = 16;

  localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_e;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [NUM_COLS-1:0] vec_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [ROW_W-1:0] row_sel;
    elem_t            elem_3;
    elem_t            elem_2;
    elem_t            elem_1;
    elem_t            elem_0;
  } in_word_t;

  typedef struct packed {
    elem_t out_x;
    elem_t out_y;
    elem_t out_z;
    elem_t out_w;
    logic  overflow;
  } out_word_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctrl_t;

endpackage

// ----- src/vmt_if.sv -----
// Valid/ready channel interfaces for input and result words.
interface vmt_in_if import vmt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vmt_out_if import vmt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/vmt_lane.sv -----
// One row lane: four products, full-width sum, shift and saturation.
module vmt_lane import vmt_pkg::*; (
  input  logic        clk_i,
  input  lane_ctrl_t  ctrl_i,
  input  vec_t        vec_i,
  input  vec_t        coef_i,
  output elem_t       res_o,
  output logic        sat_o
);

  logic signed [PROD_W-1:0] prod_q [NUM_COLS];
  logic signed [ACC_W-1:0]  sum_d;
  logic signed [ACC_W-1:0]  sum_q;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-ELEM_W:0]    top_bits;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prod_q[c] <= $signed(vec_i[c]) * $signed(coef_i[c]);
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      sum_d = sum_d + ACC_W'(prod_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_sum) begin
      sum_q <= sum_d;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign shifted  = sum_q >>> FRAC_BITS;
  assign top_bits = shifted[ACC_W-1:ELEM_W-1];
  assign sat_o    = !((&top_bits) || !(|top_bits));

  always_comb begin
    if (sat_o) begin
      res_o = shifted[ACC_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      res_o = shifted[ELEM_W-1:0];
    end
  end

endmodule

// ----- src/vmt_merge.sv -----
// Merge stage: gathers lane results into the output word register.
module vmt_merge import vmt_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  vec_t      res_i,
  input  logic [NUM_ROWS-1:0] sat_i,
  output out_word_t word_o
);

  out_word_t word_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q.out_x    <= res_i[0];
      word_q.out_y    <= res_i[1];
      word_q.out_z    <= res_i[2];
      word_q.out_w    <= res_i[3];
      word_q.overflow <= |sat_i;
    end
  end

  assign word_o = word_q;

endmodule

// ----- src/vector_matrix_transform_4x4.sv -----
// Top level: matrix store, four row lanes, merge stage and pipeline control.
//
//  channel  dir  handshake      word
//  in_i     in   valid/ready    cmd, row_sel, elem_0..elem_3
//  out_o    out  valid/ready    out_x, out_y, out_z, out_w, overflow
//
// One word per cycle sustained without backpressure; an accepted transform
// passes through multiply, sum, then shift/saturate into the output register.
// Load words update the matrix at acceptance and produce no result.
// Reset clears the matrix and all stage valids at once.
// Each stage holds under backpressure and frees as soon as its word moves on.
module vector_matrix_transform_4x4 import vmt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  vmt_in_if.sink          in_i,
  vmt_out_if.source       out_o
);

  elem_t      mat_q [NUM_ROWS][NUM_COLS];
  logic       v1_q, v2_q, v3_q;
  logic       rdy1, rdy2, rdy3;
  logic       acc, take, load;
  lane_ctrl_t lane_ctrl;
  vec_t       vec;
  vec_t       coef [NUM_ROWS];
  vec_t       res;
  logic [NUM_ROWS-1:0] sat;

  assign rdy3 = !v3_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_i.ready = rdy1;
  assign acc  = in_i.valid && rdy1;
  assign take = acc && (in_i.data.cmd == CMD_XFORM);
  assign load = acc && (in_i.data.cmd == CMD_LOAD);

  assign vec[0] = in_i.data.elem_0;
  assign vec[1] = in_i.data.elem_1;
  assign vec[2] = in_i.data.elem_2;
  assign vec[3] = in_i.data.elem_3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          mat_q[r][c] <= '0;
        end
      end
    end else if (load) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        mat_q[in_i.data.row_sel][c] <= vec[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= take;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign lane_ctrl.en_mul = take;
  assign lane_ctrl.en_sum = rdy2 && v1_q;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_coef
      assign coef[r][c] = mat_q[r][c];
    end

    vmt_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .vec_i  (vec),
      .coef_i (coef[r]),
      .res_o  (res[r]),
      .sat_o  (sat[r])
    );
  end

  vmt_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (rdy3 && v2_q),
    .res_i  (res),
    .sat_i  (sat),
    .word_o (out_o.data)
  );

  assign out_o.valid = v3_q;

  a_load_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> !v1_q)
    else $error("load word entered the pipeline");

  a_xform_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> v1_q)
    else $error("accepted transform lost at first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |=> v2_q)
    else $error("sum stage dropped a stalled word");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && !out_o.ready))
    else $error("input stalled with room in the pipeline");

endmodule
